FILE: sv/mdbr_pkg.sv
// Shared types and constants for the MIPS decode and branch resolve stage.
// No dependencies; used by mdbr_regfile and mips_decode_branch_resolve.
package mdbr_pkg;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_BLTZ  = 6'h01;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BLEZ  = 6'h06;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2B;
  localparam logic [5:0] FN_JR    = 6'h08;

  localparam logic [4:0] LINK_REG = 5'd31;
  localparam logic [4:0] ZERO_REG = 5'd0;
  localparam logic       KIND_DECODE = 1'b0;
  localparam logic       KIND_WB     = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] instr;
    logic [31:0] next_instr;
    logic [31:0] pc;
    logic [4:0]  wb_index;
    logic [31:0] wb_value;
  } req_t;

  typedef struct packed {
    logic [31:0]        next_pc;
    logic [5:0]         opcode;
    logic [4:0]         src_reg;
    logic [4:0]         tgt_reg;
    logic [4:0]         dst_reg;
    logic [4:0]         shift_amount;
    logic [5:0]         func_code;
    logic signed [15:0] immediate;
    logic [25:0]        jump_target;
    logic               stall_flag;
    logic               redirect;
  } rsp_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } rf_wr_t;

endpackage

FILE: sv/mips_decode_branch_resolve.sv
// MIPS decode stage: field split, load-use check, branch and jump resolve.
// Depends on mdbr_pkg and mdbr_regfile.
//
//   channel | signals                  | word
//   --------+--------------------------+--------------------------------
//   request | req_valid, req_ready     | req_t: decode or write-back
//   result  | rsp_valid, rsp_ready     | rsp_t: one per decode word
//
// One word per cycle while the result channel does not stall. A decode word reads
// the register file at acceptance, resolves in the following cycle and lands in the
// result register at the end of the first cycle in which that register is free.
// Write-back words and the jal link write update the register file at
// acceptance and give no result. Reset clears all pipeline valids and the
// register file valid bits. A stalled result holds stage 1, which holds input.
module mips_decode_branch_resolve (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  mdbr_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output mdbr_pkg::rsp_t  rsp
);

  logic             req_fire;
  logic             s1_adv;
  logic             rd_en;
  mdbr_pkg::rf_wr_t wr;
  logic [31:0]      rdata_a;
  logic [31:0]      rdata_b;
  logic [31:0]      br_m1;

  logic             s1_valid;
  logic [31:0]      s1_instr;
  logic [31:0]      s1_next_instr;
  logic [31:0]      s1_pc;
  logic [31:0]      s1_br_m1;

  mdbr_pkg::rsp_t   res;
  logic [5:0]       op;
  logic [5:0]       nop;
  logic             is_load;
  logic             is_store;
  logic             taken;
  logic             force_rt;

  assign req_fire  = req_valid && req_ready;
  assign s1_adv    = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || s1_adv;
  assign rd_en     = req_fire && (req.kind == mdbr_pkg::KIND_DECODE);
  assign br_m1     = req.pc + {{16{req.instr[15]}}, req.instr[15:0]} - 32'd1;

  always_comb begin
    if (req.kind == mdbr_pkg::KIND_WB) begin
      wr.en   = req_fire;
      wr.addr = req.wb_index;
      wr.data = req.wb_value;
    end else begin
      wr.en   = req_fire && (req.instr[31:26] == mdbr_pkg::OP_JAL);
      wr.addr = mdbr_pkg::LINK_REG;
      wr.data = req.pc + 32'd2;
    end
  end

  mdbr_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .rd_en     (rd_en),
    .rd_addr_a (req.instr[25:21]),
    .rd_addr_b (req.instr[20:16]),
    .rd_data_a (rdata_a),
    .rd_data_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_instr      <= req.instr;
      s1_next_instr <= req.next_instr;
      s1_pc         <= req.pc;
      s1_br_m1      <= br_m1;
    end
  end

  always_comb begin
    op  = s1_instr[31:26];
    nop = s1_next_instr[31:26];

    unique case (op) inside
      mdbr_pkg::OP_LW, mdbr_pkg::OP_LB, mdbr_pkg::OP_LBU, mdbr_pkg::OP_LHU: is_load = 1'b1;
      default: is_load = 1'b0;
    endcase
    unique case (nop) inside
      mdbr_pkg::OP_SW, mdbr_pkg::OP_SH, mdbr_pkg::OP_SB: is_store = 1'b1;
      default: is_store = 1'b0;
    endcase

    force_rt = 1'b0;
    unique case (op)
      mdbr_pkg::OP_BEQ: taken = (rdata_a == rdata_b);
      mdbr_pkg::OP_BNE: taken = (rdata_a != rdata_b);
      mdbr_pkg::OP_BGTZ: begin
        taken    = !rdata_a[31] && (rdata_a != '0);
        force_rt = taken;
      end
      mdbr_pkg::OP_BLTZ: begin
        taken    = rdata_a[31];
        force_rt = taken;
      end
      mdbr_pkg::OP_BLEZ: begin
        taken    = rdata_a[31] || (rdata_a == '0);
        force_rt = taken;
      end
      default: taken = 1'b0;
    endcase

    res.opcode     = op;
    res.src_reg    = s1_instr[25:21];
    res.tgt_reg    = force_rt ? 5'd1 : s1_instr[20:16];
    res.stall_flag = is_load && !is_store &&
                     (s1_instr[20:16] == s1_next_instr[25:21] ||
                      s1_instr[20:16] == s1_next_instr[20:16]);
    if (op == mdbr_pkg::OP_RTYPE) begin
      res.dst_reg      = s1_instr[15:11];
      res.shift_amount = s1_instr[10:6];
      res.func_code    = s1_instr[5:0];
      res.immediate    = '0;
      res.jump_target  = '0;
    end else begin
      res.dst_reg      = '0;
      res.shift_amount = '0;
      res.func_code    = '0;
      res.immediate    = s1_instr[15:0];
      res.jump_target  = s1_instr[25:0];
    end

    res.redirect = taken;
    res.next_pc  = taken ? s1_br_m1 : s1_pc;
    if (op == mdbr_pkg::OP_J || op == mdbr_pkg::OP_JAL) begin
      res.redirect = 1'b1;
      res.next_pc  = {6'd0, s1_instr[25:0]} - 32'd1;
    end else if (op == mdbr_pkg::OP_RTYPE && s1_instr[5:0] == mdbr_pkg::FN_JR) begin
      res.redirect = 1'b1;
      res.next_pc  = rdata_a - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      rsp <= res;
    end
  end

  a_wb_no_result: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.kind == mdbr_pkg::KIND_WB |=> !s1_valid)
    else $error("write-back word entered the result path");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_instr) && $stable(s1_pc))
    else $error("stage 1 lost a stalled word");

  a_jump_target: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.opcode == mdbr_pkg::OP_J || rsp.opcode == mdbr_pkg::OP_JAL)
    |-> rsp.redirect && rsp.next_pc == {6'd0, rsp.jump_target} - 32'd1)
    else $error("jump did not redirect to its target");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready && s1_valid |-> !req_ready)
    else $error("input taken while both stages are full");

endmodule

FILE: sv/mdbr_regfile.sv
// 32 x 32 register file, one write port and two registered read ports.
// Per-entry valid bits give zero for unwritten entries and for register zero.
// Depends on mdbr_pkg.
module mdbr_regfile (
  input  logic                 clk,
  input  logic                 rst,
  input  mdbr_pkg::rf_wr_t     wr,
  input  logic                 rd_en,
  input  logic [4:0]           rd_addr_a,
  input  logic [4:0]           rd_addr_b,
  output logic [31:0]          rd_data_a,
  output logic [31:0]          rd_data_b
);

  logic [31:0] mem [32];
  logic [31:0] valid;
  logic [31:0] raw_a;
  logic [31:0] raw_b;
  logic        ok_a;
  logic        ok_b;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      raw_a <= mem[rd_addr_a];
      raw_b <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ok_a  <= 1'b0;
      ok_b  <= 1'b0;
    end else begin
      if (wr.en && wr.addr != mdbr_pkg::ZERO_REG) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        ok_a <= valid[rd_addr_a];
        ok_b <= valid[rd_addr_b];
      end
    end
  end

  assign rd_data_a = ok_a ? raw_a : '0;
  assign rd_data_b = ok_b ? raw_b : '0;

endmodule
